// ----- hdl/if_startup_angle_generator_assert.svh -----
// assertion macros used by the checker of this block
`ifndef IF_STARTUP_ANGLE_GENERATOR_ASSERT_SVH
`define IF_STARTUP_ANGLE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ISAG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isag assertion failed");

// next-cycle implication
`define ISAG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isag assertion failed");

`endif

// ----- hdl/isag_pkg.sv -----
package isag_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;
  localparam int HoldW    = 24;

  localparam logic [CfgIdxW-1:0] CFG_CURRENT_TARGET = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT_STEP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_STEP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_GAIN     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_OFFSET   = 3'd5;

  localparam logic [31:0] ANGLE_START = 32'hC000_0000;

  typedef enum logic [1:0] {
    PH_CURRENT = 2'd0,
    PH_HOLD    = 2'd1,
    PH_SPEED   = 2'd2
  } phase_t;

  // q15 to q15.16
  function automatic logic signed [31:0] q15_wide(input logic signed [15:0] v);
    return {v, 16'h0000};
  endfunction

  // one ramp step toward tgt, clamped at tgt; zero step counts as one
  function automatic logic signed [31:0] ramp(input logic signed [31:0] acc,
                                              input logic signed [31:0] tgt,
                                              input logic [30:0] step);
    logic [30:0]        s;
    logic signed [32:0] up;
    logic signed [32:0] dn;
    logic signed [32:0] t33;
    logic signed [31:0] res;
    s   = (step == 31'd0) ? 31'd1 : step;
    up  = 33'(acc) + $signed({2'b00, s});
    dn  = 33'(acc) - $signed({2'b00, s});
    t33 = 33'(tgt);
    if (acc < tgt) begin
      res = (up > t33) ? tgt : up[31:0];
    end else if (acc > tgt) begin
      res = (dn < t33) ? tgt : dn[31:0];
    end else begin
      res = acc;
    end
    return res;
  endfunction

endpackage

// ----- hdl/if_startup_angle_generator.sv -----
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
// in       | in_valid/in_ready, in_mode, speed_target  | in
// out      | out_valid/out_ready, magnitude, angle,    | out
//          | speed, phase, steady_reached              |
//
// two register stages: ramps and hold counter update at request accept,
// the speed-times-gain product and angle add fill the output register next.
// a request's result waits in the first stage until the output register is
// free; one request per cycle while the output is not stalled.
// rst_n is synchronous; config returns to its defaults, angle to -90 degrees.
// a stalled output holds both stages; cfg_ready is always high.
module if_startup_angle_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [isag_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [isag_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic signed [15:0]                in_speed_target,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_current_magnitude,
  output logic [15:0]                       out_angle,
  output logic signed [15:0]                out_speed,
  output logic [1:0]                        out_phase,
  output logic                              out_steady_reached
);
  import isag_pkg::*;

  typedef struct packed {
    logic               restart;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    phase_t             phase;
    logic               steady;
  } mid_t;

  logic signed [15:0] cur_tgt_r;
  logic [30:0]        cur_step_r;
  logic [30:0]        spd_step_r;
  logic [HoldW-1:0]   hold_ticks_r;
  logic [15:0]        angle_gain_r;
  logic [15:0]        angle_offset_r;

  logic signed [31:0] cur_acc_r, cur_acc_nxt;
  logic signed [31:0] spd_acc_r, spd_acc_nxt;
  logic [HoldW-1:0]   hold_ctr_r, hold_ctr_nxt;
  logic signed [15:0] spd_goal;
  logic [31:0]        angle_r, angle_nxt;

  logic               mid_valid_r;
  mid_t               mid_r, mid_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_cur_r;
  logic [15:0]        out_angle_r;
  logic signed [15:0] out_spd_r;
  phase_t             out_phase_r;
  logic               out_steady_r;

  logic               in_acc;
  logic               mid_adv;
  logic               out_free;
  logic signed [31:0] itgt;
  phase_t             phase;
  logic signed [32:0] prod;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign mid_adv   = mid_valid_r && out_free;
  assign in_ready  = !mid_valid_r || mid_adv;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_tgt_r      <= '0;
      cur_step_r     <= 31'd1;
      spd_step_r     <= 31'd1;
      hold_ticks_r   <= '0;
      angle_gain_r   <= '0;
      angle_offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CURRENT_TARGET: cur_tgt_r      <= cfg_data[15:0];
        CFG_CURRENT_STEP:   cur_step_r     <= cfg_data;
        CFG_SPEED_STEP:     spd_step_r     <= cfg_data;
        CFG_HOLD_TICKS:     hold_ticks_r   <= cfg_data[HoldW-1:0];
        CFG_ANGLE_GAIN:     angle_gain_r   <= cfg_data[15:0];
        CFG_ANGLE_OFFSET:   angle_offset_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ramp stage
  assign itgt = q15_wide(cur_tgt_r);

  always_comb begin
    cur_acc_nxt  = cur_acc_r;
    spd_acc_nxt  = spd_acc_r;
    hold_ctr_nxt = hold_ctr_r;
    spd_goal     = in_speed_target;
    phase        = PH_CURRENT;
    if (in_mode) begin
      cur_acc_nxt  = '0;
      spd_acc_nxt  = '0;
      hold_ctr_nxt = '0;
      spd_goal     = '0;
    end else if (cur_acc_r != itgt) begin
      cur_acc_nxt = ramp(cur_acc_r, itgt, cur_step_r);
    end else if (hold_ctr_r < hold_ticks_r) begin
      hold_ctr_nxt = hold_ctr_r + 1'b1;
      phase        = PH_HOLD;
    end else begin
      spd_acc_nxt = ramp(spd_acc_r, q15_wide(in_speed_target), spd_step_r);
      phase       = PH_SPEED;
    end
    mid_nxt.restart = in_mode;
    mid_nxt.current = cur_acc_nxt[31:16];
    mid_nxt.speed   = spd_acc_nxt[31:16];
    mid_nxt.phase   = phase;
    mid_nxt.steady  = (cur_acc_nxt == itgt) && (spd_acc_nxt == q15_wide(spd_goal));
  end

  // angle stage
  assign prod      = mid_r.speed * $signed({1'b0, angle_gain_r});
  assign angle_nxt = mid_r.restart ? ANGLE_START : angle_r + prod[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_acc_r   <= '0;
      spd_acc_r   <= '0;
      hold_ctr_r  <= '0;
      angle_r     <= ANGLE_START;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_acc_r  <= cur_acc_nxt;
        spd_acc_r  <= spd_acc_nxt;
        hold_ctr_r <= hold_ctr_nxt;
      end
      if (mid_adv) begin
        angle_r <= angle_nxt;
      end
      if (in_ready) begin
        mid_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= mid_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_r <= mid_nxt;
    end
    if (mid_adv) begin
      out_cur_r    <= mid_r.current;
      out_angle_r  <= angle_nxt[31:16] + angle_offset_r;
      out_spd_r    <= mid_r.speed;
      out_phase_r  <= mid_r.phase;
      out_steady_r <= mid_r.steady;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_current_magnitude = out_cur_r;
  assign out_angle             = out_angle_r;
  assign out_speed             = out_spd_r;
  assign out_phase             = out_phase_r;
  assign out_steady_reached    = out_steady_r;

endmodule

// ----- hdl/isag_checker.sv -----
`include "if_startup_angle_generator_assert.svh"

module isag_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [isag_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [isag_pkg::CfgDataW-1:0] cfg_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [15:0]            out_current_magnitude,
  input logic [15:0]                   out_angle,
  input logic [1:0]                    out_phase,
  input logic                          out_steady_reached
);
  import isag_pkg::*;

  logic signed [15:0] tgt_r;

  // shadow of the current target as written on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index == CFG_CURRENT_TARGET)) begin
      tgt_r <= cfg_data[15:0];
    end
  end

  `ISAG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_angle) && $stable(out_phase))
  `ISAG_ASSERT_IMP(a_settled_phase, clk, rst_n,
    out_valid && ((out_phase == PH_HOLD) || (out_phase == PH_SPEED)),
    out_current_magnitude == tgt_r)
  `ISAG_ASSERT_IMP(a_steady_current, clk, rst_n, out_valid && out_steady_reached,
    out_current_magnitude == tgt_r)

endmodule

bind if_startup_angle_generator isag_checker u_isag_checker (.*);

// ----- test/angle_gen_checker.sv -----
`timescale 1ns / 100ps
module angle_gen_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [isag_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [isag_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_mode,
  input  logic signed [15:0]            in_speed_target,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [15:0]            out_current_magnitude,
  input  logic [15:0]                   out_angle,
  input  logic signed [15:0]            out_speed,
  input  logic [1:0]                    out_phase,
  input  logic                          out_steady_reached,
  output int                            fails,
  output int                            due_count
);
  import isag_pkg::*;

  typedef struct {
    logic signed [15:0] magnitude;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    phase_t             phase;
    logic               steady;
  } tick_result_t;

  // register copy
  logic signed [15:0] cur_target;
  logic [30:0]        cur_inc;
  logic [30:0]        spd_inc;
  logic [23:0]        hold_len;
  logic [15:0]        gain;
  logic [15:0]        offs;

  // startup state
  logic signed [31:0] cur_acc;
  logic signed [31:0] spd_acc;
  logic [23:0]        hold_ctr;
  logic [31:0]        ang_acc;
  logic signed [15:0] spd_goal;

  tick_result_t due_ticks[$];

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fails++;
  endtask

  function automatic logic signed [31:0] step_toward(input logic signed [31:0] acc,
                                                     input logic signed [31:0] goal,
                                                     input logic [30:0] inc);
    longint a;
    longint g;
    longint s;
    a = acc;
    g = goal;
    s = (inc == 31'd0) ? 64'sd1 : longint'(inc);
    if (a < g) begin
      a = a + s;
      if (a > g) a = g;
    end else if (a > g) begin
      a = a - s;
      if (a < g) a = g;
    end
    return 32'(a);
  endfunction

  task automatic restart_startup();
    cur_acc  = '0;
    spd_acc  = '0;
    hold_ctr = '0;
    ang_acc  = ANGLE_START;
    spd_goal = '0;
  endtask

  task automatic load_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_CURRENT_TARGET: cur_target = data[15:0];
      CFG_CURRENT_STEP:   cur_inc    = data[30:0];
      CFG_SPEED_STEP:     spd_inc    = data[30:0];
      CFG_HOLD_TICKS:     hold_len   = data[23:0];
      CFG_ANGLE_GAIN:     gain       = data[15:0];
      CFG_ANGLE_OFFSET:   offs       = data[15:0];
      default: ;
    endcase
  endtask

  task automatic advance_tick(input logic mode, input logic signed [15:0] target,
                              output tick_result_t r);
    logic signed [31:0] cur_goal;
    longint             turn;
    phase_t             ph;
    cur_goal = {cur_target, 16'h0000};
    ph = PH_CURRENT;
    if (mode) begin
      restart_startup();
    end else begin
      spd_goal = target;
      if (cur_acc != cur_goal) begin
        cur_acc = step_toward(cur_acc, cur_goal, cur_inc);
      end else if (hold_ctr < hold_len) begin
        hold_ctr = hold_ctr + 24'd1;
        ph = PH_HOLD;
      end else begin
        spd_acc = step_toward(spd_acc, {spd_goal, 16'h0000}, spd_inc);
        ph = PH_SPEED;
      end
      // angle moves by the already updated speed
      turn = longint'($signed(spd_acc[31:16])) * longint'(gain);
      ang_acc = ang_acc + 32'(turn);
    end
    r.magnitude = cur_acc[31:16];
    r.angle     = ang_acc[31:16] + offs;
    r.speed     = spd_acc[31:16];
    r.phase     = ph;
    r.steady    = (cur_acc == cur_goal) && (spd_acc == {spd_goal, 16'h0000});
  endtask

  task automatic check_result();
    tick_result_t want;
    if (due_ticks.size() == 0) begin
      flag_mismatch($sformatf("result with no request pending, angle %0d", out_angle));
    end else begin
      want = due_ticks.pop_front();
      if (out_current_magnitude !== want.magnitude)
        flag_mismatch($sformatf("current_magnitude got %0d want %0d",
                                out_current_magnitude, want.magnitude));
      if (out_angle !== want.angle)
        flag_mismatch($sformatf("angle got %0d want %0d", out_angle, want.angle));
      if (out_speed !== want.speed)
        flag_mismatch($sformatf("speed got %0d want %0d", out_speed, want.speed));
      if (out_phase !== want.phase)
        flag_mismatch($sformatf("phase got %0d want %0d", out_phase, want.phase));
      if (out_steady_reached !== want.steady)
        flag_mismatch($sformatf("steady_reached got %0d want %0d",
                                out_steady_reached, want.steady));
    end
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      cur_target = '0;
      cur_inc    = 31'd1;
      spd_inc    = 31'd1;
      hold_len   = '0;
      gain       = '0;
      offs       = '0;
      restart_startup();
      due_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        advance_tick(in_mode, in_speed_target, want);
        due_ticks.push_back(want);
      end
    end
    due_count = due_ticks.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import isag_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int PhaseTicks = 78;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                in_mode;
  logic signed [15:0]  in_speed_target;
  logic                out_valid;
  logic                out_ready;
  logic signed [15:0]  out_current_magnitude;
  logic [15:0]         out_angle;
  logic signed [15:0]  out_speed;
  logic [1:0]          out_phase;
  logic                out_steady_reached;

  int fails;
  int due_count;
  int sent;
  int idle_cycles;
  bit no_gaps;

  if_startup_angle_generator u_top (.*);

  angle_gen_checker u_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_target();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] rand_step(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return 31'($urandom_range(0, 1));
      1: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [23:0] rand_hold();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 24'($urandom_range(0, 8));
    return 24'($urandom_range(9, 60));
  endfunction

  task automatic send_tick(input logic mode, input logic [15:0] target);
    int n;
    n = no_gaps ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_speed_target <= target;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // drain all pending ticks, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int idx);
    logic [15:0] goal;
    int          r;
    settle();
    write_reg(CFG_CURRENT_TARGET, {15'($urandom), rand_target()});
    write_reg(CFG_CURRENT_STEP, rand_step(32'h0200_0000, 32'h2000_0000));
    write_reg(CFG_SPEED_STEP, rand_step(32'h0004_0000, 32'h0800_0000));
    write_reg(CFG_HOLD_TICKS, {7'($urandom), (idx == 5) ? 24'hFF_FFFF : rand_hold()});
    write_reg(CFG_ANGLE_GAIN, {15'($urandom), rand_word()});
    write_reg(CFG_ANGLE_OFFSET, {15'($urandom), rand_word()});
    cfg_valid <= 1'b0;
    no_gaps = ($urandom_range(0, 3) == 0);
    goal = rand_target();
    repeat (PhaseTicks) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_tick(1'b1, 16'($urandom));
      end else if (r < 10) begin
        goal = rand_target();
        send_tick(1'b0, goal);
      end else if (r < 14) begin
        send_tick(1'b0, 16'($urandom));
      end else begin
        send_tick(1'b0, goal);
      end
    end
  endtask

  // receiver side, with two long hold-offs while requests keep coming
  initial begin
    int n;
    int next_stall;
    out_ready = 1'b0;
    next_stall = 300;
    @(negedge clk);
    forever begin
      if (sent >= next_stall) begin
        next_stall += 400;
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("FAIL if_startup_angle_generator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_mode         = 1'b0;
    in_speed_target = '0;
    no_gaps         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults
    send_tick(1'b0, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b1, 16'h5A5A);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'h0001);

    // full steps clamp at the target, short hold, widest gain and offset
    settle();
    write_reg(CFG_CURRENT_TARGET, {15'h7FFF, 16'h8000});
    write_reg(CFG_CURRENT_STEP, 31'h7FFF_FFFF);
    write_reg(CFG_SPEED_STEP, 31'h7FFF_FFFF);
    write_reg(CFG_HOLD_TICKS, 31'd2);
    write_reg(CFG_ANGLE_GAIN, 31'h0000_FFFF);
    write_reg(CFG_ANGLE_OFFSET, 31'h0000_FFFF);
    cfg_valid <= 1'b0;
    repeat (4) send_tick(1'b0, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'd100);
    send_tick(1'b0, 16'd100);

    // zero steps count as one, unused indexes are ignored
    settle();
    write_reg(CFG_CURRENT_TARGET, 31'h0000_7FFF);
    write_reg(CFG_CURRENT_STEP, 31'd0);
    write_reg(CFG_SPEED_STEP, 31'd0);
    write_reg(CFG_HOLD_TICKS, {7'h7F, 24'd0});
    write_reg(CFG_ANGLE_GAIN, {15'h7FFF, 16'h0000});
    write_reg(CFG_ANGLE_OFFSET, {15'h7FFF, 16'h0000});
    write_reg(CFG_SPARE_LO, 31'h7FFF_FFFF);
    write_reg(CFG_SPARE_HI, 31'h7FFF_FFFF);
    cfg_valid <= 1'b0;
    repeat (3) send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'h0000);

    for (int p = 0; p < 12; p++) random_phase(p);

    settle();
    if (fails == 0) begin
      $display("PASS if_startup_angle_generator");
    end else begin
      $display("FAIL if_startup_angle_generator");
    end
    $finish;
  end

endmodule
